// ===== rtl/gwff_pkg.sv =====
`default_nettype none

package gwff_pkg;

   localparam int DEF_RADIUS    = 7;
   localparam int DEF_GRID_SIDE = 15;

   localparam int AGE_W = 10;
   localparam logic [AGE_W-1:0] LIFETIME_RESET = AGE_W'(50);

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_TICK  = 2'd2,
      FUNC_QUERY = 2'd3
   } func_type;

   typedef struct packed {
      func_type           func;
      logic [3:0]         cell_row;
      logic [3:0]         cell_col;
      logic               cell_blocked;
      logic signed [7:0]  offset_x;
      logic signed [7:0]  offset_y;
   } req_word_type;

   typedef struct packed {
      logic hit;
      logic expired;
   } rsp_word_type;

   // broadcast to every cell
   typedef struct packed {
      logic load;
      logic start;
      logic grow;
      logic blocked;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/grid_wavefront_flood_fill_unit.sv =====
`default_nettype none

// channel   dir  handshake              payload
// req       in   req_valid/req_ready    req_word  (req_word_type)
// rsp       out  rsp_valid/rsp_ready    rsp_word  (rsp_word_type)
// csr       in   csr_we                 csr_wdata (lifetime, 10 bits)
//
// One word per cycle unless rsp stalls: every cell updates from its four
// neighbors on a growing tick; a query reads the cell grid in its accept cycle.
// The result sits in one output register; a new word is taken while it drains.
// Synchronous reset: all cells blocked and unreached, age and expiry cleared.
// A stalled rsp channel holds req_ready low once the output register is full.

module grid_wavefront_flood_fill_unit
   import gwff_pkg::*;
#(
   parameter int RADIUS    = DEF_RADIUS,
   parameter int GRID_SIDE = DEF_GRID_SIDE
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_word_type       req_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_word_type            rsp_word,
   input  wire logic               csr_we,
   input  wire logic [AGE_W-1:0]   csr_wdata
);

   localparam int IDX_W = $clog2(GRID_SIDE);

   logic [AGE_W-1:0] lifetime_ff;
   logic [AGE_W-1:0] age_ff, age_in;
   logic             expired_ff, expired_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic             accept;
   cell_ctl_type     ctl;
   logic             tick_live;

   logic [GRID_SIDE-1:0] reached_w [GRID_SIDE];
   logic [3:0]           nb_w      [GRID_SIDE][GRID_SIDE];

   logic signed [9:0] tx, ty;
   logic              in_grid;
   logic              query_bit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign tick_live = accept && (req_word.func == FUNC_TICK) && !expired_ff;

   assign ctl.load    = accept && (req_word.func == FUNC_LOAD);
   assign ctl.start   = accept && (req_word.func == FUNC_START);
   assign ctl.grow    = tick_live && (age_ff < lifetime_ff);
   assign ctl.blocked = req_word.cell_blocked;

   for (genvar r = 0; r < GRID_SIDE; r++) begin : g_row
      for (genvar c = 0; c < GRID_SIDE; c++) begin : g_col
         localparam int DX = c - RADIUS;
         localparam int DY = r - RADIUS;
         localparam bit OUT = (DX * DX + DY * DY) > (RADIUS * RADIUS);
         localparam bit CTR = (r == RADIUS) && (c == RADIUS);

         logic sel;
         assign sel = (int'(req_word.cell_row) == r) && (int'(req_word.cell_col) == c);

         if (c > 0) begin : g_w
            assign nb_w[r][c][0] = reached_w[r][c-1];
         end else begin : g_nw
            assign nb_w[r][c][0] = 1'b0;
         end
         if (c < GRID_SIDE - 1) begin : g_e
            assign nb_w[r][c][1] = reached_w[r][c+1];
         end else begin : g_ne
            assign nb_w[r][c][1] = 1'b0;
         end
         if (r > 0) begin : g_n
            assign nb_w[r][c][2] = reached_w[r-1][c];
         end else begin : g_nn
            assign nb_w[r][c][2] = 1'b0;
         end
         if (r < GRID_SIDE - 1) begin : g_s
            assign nb_w[r][c][3] = reached_w[r+1][c];
         end else begin : g_ns
            assign nb_w[r][c][3] = 1'b0;
         end

         gwff_cell #(
            .IS_CENTER (CTR),
            .OUTSIDE   (OUT)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .sel        (sel),
            .nb_reached (nb_w[r][c]),
            .reached    (reached_w[r][c])
         );
      end
   end

   assign tx = $signed({{2{req_word.offset_x[7]}}, req_word.offset_x}) + 10'(RADIUS);
   assign ty = $signed({{2{req_word.offset_y[7]}}, req_word.offset_y}) + 10'(RADIUS);
   assign in_grid = (tx >= 0) && (int'(tx) < GRID_SIDE) && (ty >= 0) && (int'(ty) < GRID_SIDE);

   always_comb begin
      query_bit = 1'b0;
      if (in_grid) begin
         query_bit = reached_w[ty[IDX_W-1:0]][tx[IDX_W-1:0]];
      end
   end

   always_comb begin
      age_in     = age_ff;
      expired_in = expired_ff;
      if (ctl.start) begin
         age_in     = '0;
         expired_in = 1'b0;
      end else if (ctl.grow) begin
         age_in = age_ff + AGE_W'(1);
      end else if (tick_live) begin
         expired_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_word_in.expired = expired_in;
         rsp_word_in.hit     = 1'b0;
         unique case (req_word.func)
            FUNC_QUERY: rsp_word_in.hit = query_bit && !expired_ff;
            default: rsp_word_in.hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff  <= LIFETIME_RESET;
         age_ff       <= '0;
         expired_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            lifetime_ff <= csr_wdata;
         end
         age_ff       <= age_in;
         expired_ff   <= expired_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_expire_on_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(expired_ff) |-> $past(accept && (req_word.func == FUNC_TICK)))
      else $error("expiry set without a tick");

   a_age_moves_on_cmd: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(age_ff)) |->
         $past(accept && (req_word.func == FUNC_TICK || req_word.func == FUNC_START)))
      else $error("age changed without tick or start");

   a_hit_not_expired: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.hit) |-> !rsp_word_ff.expired)
      else $error("hit reported on expired wave");

endmodule

`default_nettype wire

// ===== rtl/gwff_cell.sv =====
`default_nettype none

module gwff_cell
   import gwff_pkg::*;
#(
   parameter bit IS_CENTER = 1'b0,
   parameter bit OUTSIDE   = 1'b0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire logic         sel,
   input  wire logic [3:0]   nb_reached,
   output logic              reached
);

   logic blocked_ff, blocked_in;
   logic reached_ff, reached_in;

   always_comb begin
      blocked_in = blocked_ff;
      reached_in = reached_ff;
      if (ctl.load && sel) begin
         blocked_in = ctl.blocked | OUTSIDE;
      end
      if (ctl.start) begin
         reached_in = IS_CENTER;
      end else if (ctl.load && sel) begin
         reached_in = 1'b0;
      end else if (ctl.grow) begin
         reached_in = reached_ff | (!blocked_ff && (|nb_reached));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= 1'b1;
         reached_ff <= 1'b0;
      end else begin
         blocked_ff <= blocked_in;
         reached_ff <= reached_in;
      end
   end

   assign reached = reached_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import gwff_pkg::*;

   localparam int RAD = DEF_RADIUS;
   localparam int GS = DEF_GRID_SIDE;
   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int WORD_TARGET = 1250;

   typedef bit cell_map_type [GS][GS];
   typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN, SINK_SPARSE} sink_mode_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_word_type req_word;
   logic rsp_valid;
   logic rsp_ready;
   rsp_word_type rsp_word;
   logic csr_we;
   logic [AGE_W-1:0] csr_wdata;

   cell_map_type blocked_map;
   cell_map_type reached_map;
   logic [AGE_W-1:0] wave_age;
   bit wave_expired;
   logic [AGE_W-1:0] lifetime_reg;

   rsp_word_type wave_results_due[$];
   int error_count;
   int words_sent;
   int func_count[4];
   int hits_seen;
   int expiries_seen;
   int quiet_cycles;
   int burst_left;
   bit gaps_on;
   bit hold_request;

   grid_wavefront_flood_fill_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_word_type predict_wave_step(req_word_type w);
      rsp_word_type r;
      cell_map_type grown;
      int dx;
      int dy;
      int tx;
      int ty;
      r = '0;
      case (w.func)
         FUNC_LOAD: begin
            if (w.cell_row < GS && w.cell_col < GS) begin
               dy = int'(w.cell_row) - RAD;
               dx = int'(w.cell_col) - RAD;
               blocked_map[w.cell_row][w.cell_col] =
                  w.cell_blocked || (dx * dx + dy * dy > RAD * RAD);
               reached_map[w.cell_row][w.cell_col] = 1'b0;
            end
         end
         FUNC_START: begin
            foreach (reached_map[i, j]) reached_map[i][j] = 1'b0;
            if (RAD < GS) reached_map[RAD][RAD] = 1'b1;
            wave_age = '0;
            wave_expired = 1'b0;
         end
         FUNC_TICK: begin
            if (!wave_expired) begin
               if (wave_age >= lifetime_reg) begin
                  wave_expired = 1'b1;
               end else begin
                  foreach (grown[i, j]) begin
                     grown[i][j] = reached_map[i][j];
                     if (!reached_map[i][j] && !blocked_map[i][j]) begin
                        if ((j > 0 && reached_map[i][j-1]) ||
                            (j < GS - 1 && reached_map[i][j+1]) ||
                            (i > 0 && reached_map[i-1][j]) ||
                            (i < GS - 1 && reached_map[i+1][j]))
                           grown[i][j] = 1'b1;
                     end
                  end
                  reached_map = grown;
                  wave_age = wave_age + 1'b1;
               end
            end
         end
         default: begin
            tx = RAD + int'($signed(w.offset_x));
            ty = RAD + int'($signed(w.offset_y));
            if (tx >= 0 && tx < GS && ty >= 0 && ty < GS && !wave_expired)
               r.hit = reached_map[ty][tx];
         end
      endcase
      r.expired = wave_expired;
      return r;
   endfunction

   function automatic req_word_type rand_word();
      req_word_type w;
      w.func = func_type'($urandom_range(0, 3));
      w.cell_row = 4'($urandom_range(0, 15));
      w.cell_col = 4'($urandom_range(0, 15));
      w.cell_blocked = 1'($urandom_range(0, 1));
      w.offset_x = 8'($urandom_range(0, 255));
      w.offset_y = 8'($urandom_range(0, 255));
      return w;
   endfunction

   function automatic req_word_type mk_word(func_type f, int row, int col, bit blk, int ox, int oy);
      req_word_type w;
      w = rand_word();
      w.func = f;
      w.cell_row = 4'(row);
      w.cell_col = 4'(col);
      w.cell_blocked = blk;
      w.offset_x = 8'(ox);
      w.offset_y = 8'(oy);
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0 || !gaps_on) ? 0 : $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid = 1'b1;
      req_word = w;
      do @(posedge clock); while (!req_ready);
      wave_results_due.push_back(predict_wave_step(w));
      func_count[w.func]++;
      words_sent++;
   endtask

   task automatic drain_all();
      @(negedge clock);
      req_valid = 1'b0;
      while (wave_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_lifetime(input logic [AGE_W-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      lifetime_reg = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic test_directed_wave();
      send_word(mk_word(FUNC_QUERY, 0, 0, 0, 0, 0));
      send_word(mk_word(FUNC_TICK, 0, 0, 0, 0, 0));    // tick before any start
      send_word(mk_word(FUNC_LOAD, 15, 3, 0, 0, 0));   // outside grid
      send_word(mk_word(FUNC_LOAD, 3, 15, 0, 0, 0));
      send_word(mk_word(FUNC_LOAD, 7, 8, 0, 0, 0));
      send_word(mk_word(FUNC_LOAD, 7, 9, 0, 0, 0));
      send_word(mk_word(FUNC_LOAD, 0, 0, 0, 0, 0));    // corner forced blocked
      send_word(mk_word(FUNC_LOAD, 0, 7, 0, 0, 0));    // on the circle, stays free
      send_word(mk_word(FUNC_START, 0, 0, 0, 0, 0));   // centre still blocked
      send_word(mk_word(FUNC_QUERY, 0, 0, 0, 0, 0));
      send_word(mk_word(FUNC_TICK, 0, 0, 0, 0, 0));
      send_word(mk_word(FUNC_TICK, 0, 0, 0, 0, 0));
      send_word(mk_word(FUNC_QUERY, 0, 0, 0, 2, 0));
      send_word(mk_word(FUNC_LOAD, 7, 9, 1, 0, 0));    // reload reached cell
      send_word(mk_word(FUNC_QUERY, 0, 0, 0, 2, 0));
      send_word(mk_word(FUNC_QUERY, 0, 0, 0, -128, 127));
      send_word(mk_word(FUNC_QUERY, 0, 0, 0, 127, -128));
      send_word(mk_word(FUNC_QUERY, 0, 0, 0, -7, 8));
   endtask

   task automatic test_lifetime_extremes();
      drain_all();
      write_lifetime('0);
      send_word(mk_word(FUNC_START, 0, 0, 0, 0, 0));
      send_word(mk_word(FUNC_TICK, 0, 0, 0, 0, 0));
      send_word(mk_word(FUNC_TICK, 0, 0, 0, 0, 0));    // already expired
      send_word(mk_word(FUNC_QUERY, 0, 0, 0, 0, 0));
      drain_all();
      write_lifetime('1);
      send_word(mk_word(FUNC_START, 0, 0, 0, 0, 0));
      repeat (3) send_word(mk_word(FUNC_TICK, 0, 0, 0, 0, 0));
      send_word(mk_word(FUNC_QUERY, 0, 0, 0, 1, 0));
      drain_all();
      write_lifetime(AGE_W'(1));                        // below current age
      send_word(mk_word(FUNC_TICK, 0, 0, 0, 0, 0));
      send_word(mk_word(FUNC_QUERY, 0, 0, 0, 1, 0));
      drain_all();
      write_lifetime(LIFETIME_RESET);
   endtask

   task automatic test_backpressure();
      req_word_type w;
      drain_all();
      gaps_on = 1'b0;
      hold_request = 1'b1;
      send_word(mk_word(FUNC_START, 0, 0, 0, 0, 0));
      repeat (40) begin
         w = rand_word();
         w.func = ($urandom_range(0, 1) != 0) ? FUNC_TICK : FUNC_QUERY;
         w.offset_x = 8'($urandom_range(0, 14) - 7);
         w.offset_y = 8'($urandom_range(0, 14) - 7);
         send_word(w);
      end
      gaps_on = 1'b1;
      drain_all();
   endtask

   task automatic test_random_waves();
      req_word_type w;
      int pick;
      logic [AGE_W-1:0] life;
      for (int r = 0; r < GS; r++) begin
         for (int c = 0; c < GS; c++) begin
            send_word(mk_word(FUNC_LOAD, r, c, ($urandom_range(0, 99) < 25), 0, 0));
         end
      end
      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 2) == 0) begin
            drain_all();
            pick = $urandom_range(0, 19);
            if (pick == 0) life = '0;
            else if (pick == 1) life = '1;
            else if (pick == 2) life = AGE_W'($urandom);
            else life = AGE_W'($urandom_range(1, 16));
            write_lifetime(life);
         end
         repeat ($urandom_range(0, 10)) begin
            send_word(mk_word(FUNC_LOAD, $urandom_range(0, GS - 1), $urandom_range(0, GS - 1),
                              ($urandom_range(0, 99) < 25), 0, 0));
         end
         w = rand_word();
         w.func = FUNC_START;
         send_word(w);
         repeat ($urandom_range(4, 40)) begin
            w = rand_word();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               w.func = FUNC_TICK;
            end else if (pick < 85) begin
               w.func = FUNC_QUERY;
               w.offset_x = 8'($urandom_range(0, 18) - 9);
               w.offset_y = 8'($urandom_range(0, 18) - 9);
            end else if (pick < 92) begin
               w.func = FUNC_LOAD;
               w.cell_row = 4'($urandom_range(0, GS - 1));
               w.cell_col = 4'($urandom_range(0, GS - 1));
            end
            send_word(w);
         end
      end
   endtask

   // result sink with its own stall pattern
   initial begin : rsp_sink
      sink_mode_type mode;
      int mode_left;
      int phase;
      int hold_left;
      bit hold_taken;
      rsp_ready = 1'b0;
      mode = SINK_OPEN;
      mode_left = 0;
      phase = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            case (mode)
               SINK_OPEN: rsp_ready = 1'b1;
               SINK_RANDOM: rsp_ready = ($urandom_range(0, 3) != 0);
               SINK_PATTERN: rsp_ready = ((phase % 7) < 4);
               default: rsp_ready = ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (wave_results_due.size() == 0) begin
            $display("%0t: unexpected result hit %0b expired %0b", $time,
                     rsp_word.hit, rsp_word.expired);
            error_count++;
         end else begin
            want = wave_results_due.pop_front();
            if (rsp_word.hit !== want.hit) begin
               $display("%0t: hit mismatch, expected %0b actual %0b", $time, want.hit, rsp_word.hit);
               error_count++;
            end
            if (rsp_word.expired !== want.expired) begin
               $display("%0t: expired mismatch, expected %0b actual %0b", $time,
                        want.expired, rsp_word.expired);
               error_count++;
            end
            if (want.hit) hits_seen++;
            if (want.expired) expiries_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      foreach (blocked_map[i, j]) blocked_map[i][j] = 1'b1;
      foreach (reached_map[i, j]) reached_map[i][j] = 1'b0;
      wave_age = '0;
      wave_expired = 1'b0;
      lifetime_reg = LIFETIME_RESET;
      words_sent = 0;
      burst_left = 0;
      gaps_on = 1'b1;
      hold_request = 1'b0;
      foreach (func_count[i]) func_count[i] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_wave();
      test_lifetime_extremes();
      test_backpressure();
      test_random_waves();
      drain_all();

      $display("%0d words: %0d loads, %0d starts, %0d ticks, %0d queries", words_sent,
               func_count[FUNC_LOAD], func_count[FUNC_START], func_count[FUNC_TICK],
               func_count[FUNC_QUERY]);
      $display("%0d hits and %0d expired results, lifetimes from 0 to 1023, long rsp stall",
               hits_seen, expiries_seen);
      if (error_count == 0 && wave_results_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d errors, %0d results missing", error_count, wave_results_due.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
